### hw/rtl/rate_limited_dispatch_queue_assert.svh
// Assertion macros for the RTL (included by rldq_engine)
`ifndef RATE_LIMITED_DISPATCH_QUEUE_ASSERT_SVH
`define RATE_LIMITED_DISPATCH_QUEUE_ASSERT_SVH

// same-cycle implication
`define RLDQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RLDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/rldq_pkg.sv
package rldq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_WORKERS = 8;

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int QLIM_W = (OCC_W > 5) ? OCC_W : 5;
  localparam int WCNT_W = $clog2(MAX_WORKERS + 1);
  localparam int MT_W   = 28;
  localparam int PROD_W = 32;

  localparam logic [MT_W-1:0] TOKEN_MILLI = MT_W'(1000);

  localparam logic [15:0] TPS_RESET     = 16'd10;
  localparam logic [4:0]  QSIZE_RESET   = 5'd16;
  localparam logic [3:0]  WORKERS_RESET = 4'd4;

  typedef enum logic [1:0] {
    ACT_ENQUEUE = 2'd0,
    ACT_TICK    = 2'd1,
    ACT_CLEAR   = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    REG_TPS     = 2'd0,
    REG_QSIZE   = 2'd1,
    REG_WORKERS = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] tag;
    logic [7:0]  retries;
    logic [15:0] backoff;
  } task_t;

  localparam int TASK_W = $bits(task_t);

  typedef struct packed {
    logic [15:0]       tps;
    logic [MT_W-1:0]   cap;
    logic [QLIM_W-1:0] qlimit;
    logic [WCNT_W-1:0] workers;
  } cfg_t;

  function automatic logic [MT_W-1:0] token_cap(input logic [15:0] tps);
    logic [MT_W-1:0] t;
    t = MT_W'(tps);
    return (t << 11) - (t << 5) - (t << 4);
  endfunction

endpackage

### hw/rtl/rate_limited_dispatch_queue.sv
// Enqueue, clear and unused actions each give one beat from the EMIT state after acceptance.
// Tick: multiply, then refill, then dispatch beats, each read from the task store (READ, then OUT);
// a tick with no dispatch gives one beat from EMIT instead. The output can stall on out_ready.
// A new action is taken only in IDLE, after the last beat of the one before has been issued.
// Reset (rst_n, synchronous): queue empty, tokens zero, registers at their defaults.
// The task store has no reset; only occupied entries are ever read.
module rate_limited_dispatch_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_task_tag,
  input  logic [7:0]  in_max_retries,
  input  logic [15:0] in_backoff_ms,
  input  logic [15:0] in_elapsed_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_accepted,
  output logic        out_dispatched,
  output logic [2:0]  out_worker_index,
  output logic [31:0] out_tag,
  output logic [7:0]  out_retries,
  output logic [15:0] out_backoff_ms,
  output logic        out_last
);
  import rldq_pkg::*;

  cfg_t             cfg;
  logic             ram_we, ram_re;
  logic [PTR_W-1:0] ram_waddr, ram_raddr;
  task_t            ram_wdata, ram_rdata;

  rldq_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rldq_task_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (TASK_W),
    .AW    (PTR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rldq_engine u_engine (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_task_tag      (in_task_tag),
    .in_max_retries   (in_max_retries),
    .in_backoff_ms    (in_backoff_ms),
    .in_elapsed_ms    (in_elapsed_ms),
    .ram_we           (ram_we),
    .ram_waddr        (ram_waddr),
    .ram_wdata        (ram_wdata),
    .ram_re           (ram_re),
    .ram_raddr        (ram_raddr),
    .ram_rdata        (ram_rdata),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_accepted     (out_accepted),
    .out_dispatched   (out_dispatched),
    .out_worker_index (out_worker_index),
    .out_tag          (out_tag),
    .out_retries      (out_retries),
    .out_backoff_ms   (out_backoff_ms),
    .out_last         (out_last)
  );

endmodule

### hw/rtl/rldq_task_ram.sv
module rldq_task_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 56,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/rldq_cfg.sv
module rldq_cfg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output rldq_pkg::cfg_t cfg
);
  import rldq_pkg::*;

  logic [15:0]     tps_r, tps_nxt;
  logic [MT_W-1:0] cap_r, cap_nxt;
  logic [4:0]      qsize_r, qsize_nxt;
  logic [3:0]      workers_r, workers_nxt;
  logic            wr_en;
  reg_idx_t        idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_comb begin
    tps_nxt     = tps_r;
    cap_nxt     = cap_r;
    qsize_nxt   = qsize_r;
    workers_nxt = workers_r;
    if (wr_en) begin
      unique case (idx)
        REG_TPS: begin
          tps_nxt = (pwdata[15:0] == 16'd0) ? 16'd1 : pwdata[15:0];
          cap_nxt = token_cap(tps_nxt);
        end
        REG_QSIZE:   qsize_nxt   = pwdata[4:0];
        REG_WORKERS: workers_nxt = pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r     <= TPS_RESET;
      cap_r     <= token_cap(TPS_RESET);
      qsize_r   <= QSIZE_RESET;
      workers_r <= WORKERS_RESET;
    end else begin
      tps_r     <= tps_nxt;
      cap_r     <= cap_nxt;
      qsize_r   <= qsize_nxt;
      workers_r <= workers_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      REG_TPS:     prdata = {16'd0, tps_r};
      REG_QSIZE:   prdata = {27'd0, qsize_r};
      REG_WORKERS: prdata = {28'd0, workers_r};
      default:     prdata = 32'd0;
    endcase
  end

  always_comb begin
    cfg.tps = tps_r;
    cfg.cap = cap_r;
    if (QLIM_W'(qsize_r) > QLIM_W'(QUEUE_DEPTH)) begin
      cfg.qlimit = QLIM_W'(QUEUE_DEPTH);
    end else begin
      cfg.qlimit = QLIM_W'(qsize_r);
    end
    if (workers_r == 4'd0) begin
      cfg.workers = WCNT_W'(1);
    end else if ({28'd0, workers_r} > 32'(MAX_WORKERS)) begin
      cfg.workers = WCNT_W'(MAX_WORKERS);
    end else begin
      cfg.workers = WCNT_W'(workers_r);
    end
  end

endmodule

### hw/rtl/rldq_engine.sv
module rldq_engine (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rldq_pkg::cfg_t             cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_action,
  input  logic [31:0]                in_task_tag,
  input  logic [7:0]                 in_max_retries,
  input  logic [15:0]                in_backoff_ms,
  input  logic [15:0]                in_elapsed_ms,
  output logic                       ram_we,
  output logic [rldq_pkg::PTR_W-1:0] ram_waddr,
  output rldq_pkg::task_t            ram_wdata,
  output logic                       ram_re,
  output logic [rldq_pkg::PTR_W-1:0] ram_raddr,
  input  rldq_pkg::task_t            ram_rdata,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_accepted,
  output logic                       out_dispatched,
  output logic [2:0]                 out_worker_index,
  output logic [31:0]                out_tag,
  output logic [7:0]                 out_retries,
  output logic [15:0]                out_backoff_ms,
  output logic                       out_last
);
  import rldq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REFILL,
    ST_READ,
    ST_OUT,
    ST_EMIT
  } state_t;

  state_t            state_r, state_nxt;
  logic [PTR_W-1:0]  head_r, head_nxt, tail_r, tail_nxt;
  logic [OCC_W-1:0]  occ_r, occ_nxt;
  logic [MT_W-1:0]   milli_r, milli_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [WCNT_W-1:0] wcnt_r, wcnt_nxt;
  logic [2:0]        widx_r, widx_nxt;
  logic              pend_r, pend_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_acc_r, out_acc_nxt;
  logic              out_disp_r, out_disp_nxt;
  logic [2:0]        out_widx_r, out_widx_nxt;
  task_t             out_task_r, out_task_nxt;
  logic              out_last_r, out_last_nxt;

  logic              slot_free;
  logic              can_disp;
  logic [PROD_W:0]   refill_sum;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign slot_free  = !out_valid_r || out_ready;
  assign can_disp   = (wcnt_r < cfg.workers) && (milli_r >= TOKEN_MILLI) && (occ_r != '0);
  assign refill_sum = (PROD_W + 1)'(milli_r) + (PROD_W + 1)'(prod_r);
  assign in_ready   = (state_r == ST_IDLE);

  assign ram_waddr       = tail_r;
  assign ram_wdata.tag     = in_task_tag;
  assign ram_wdata.retries = in_max_retries;
  assign ram_wdata.backoff = in_backoff_ms;
  assign ram_raddr       = head_r;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    occ_nxt       = occ_r;
    milli_nxt     = milli_r;
    prod_nxt      = prod_r;
    wcnt_nxt      = wcnt_r;
    widx_nxt      = widx_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_acc_nxt   = out_acc_r;
    out_disp_nxt  = out_disp_r;
    out_widx_nxt  = out_widx_r;
    out_task_nxt  = out_task_r;
    out_last_nxt  = out_last_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          pend_nxt  = 1'b0;
          state_nxt = ST_EMIT;
          unique case (action_t'(in_action))
            ACT_ENQUEUE: begin
              if (QLIM_W'(occ_r) < cfg.qlimit) begin
                ram_we   = 1'b1;
                tail_nxt = ptr_inc(tail_r);
                occ_nxt  = occ_r + OCC_W'(1);
                pend_nxt = 1'b1;
              end
            end
            ACT_TICK: begin
              prod_nxt  = PROD_W'(in_elapsed_ms) * PROD_W'(cfg.tps);
              state_nxt = ST_REFILL;
            end
            ACT_CLEAR: begin
              head_nxt = '0;
              tail_nxt = '0;
              occ_nxt  = '0;
            end
            default: ;
          endcase
        end
      end
      ST_REFILL: begin
        if (refill_sum > (PROD_W + 1)'(cfg.cap)) begin
          milli_nxt = cfg.cap;
        end else begin
          milli_nxt = MT_W'(refill_sum);
        end
        wcnt_nxt  = '0;
        state_nxt = ST_READ;
      end
      ST_READ: begin
        if (can_disp) begin
          ram_re    = 1'b1;
          head_nxt  = ptr_inc(head_r);
          occ_nxt   = occ_r - OCC_W'(1);
          milli_nxt = milli_r - TOKEN_MILLI;
          widx_nxt  = 3'(wcnt_r);
          wcnt_nxt  = wcnt_r + WCNT_W'(1);
          state_nxt = ST_OUT;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = ST_EMIT;
        end
      end
      ST_OUT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_acc_nxt   = 1'b0;
          out_disp_nxt  = 1'b1;
          out_widx_nxt  = widx_r;
          out_task_nxt  = ram_rdata;
          out_last_nxt  = !can_disp;
          state_nxt     = can_disp ? ST_READ : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_acc_nxt   = pend_r;
          out_disp_nxt  = 1'b0;
          out_widx_nxt  = '0;
          out_task_nxt  = '0;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      milli_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      occ_r       <= occ_nxt;
      milli_r     <= milli_nxt;
      out_valid_r <= out_valid_nxt;
    end
    prod_r     <= prod_nxt;
    wcnt_r     <= wcnt_nxt;
    widx_r     <= widx_nxt;
    pend_r     <= pend_nxt;
    out_acc_r  <= out_acc_nxt;
    out_disp_r <= out_disp_nxt;
    out_widx_r <= out_widx_nxt;
    out_task_r <= out_task_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_accepted     = out_acc_r;
  assign out_dispatched   = out_disp_r;
  assign out_worker_index = out_widx_r;
  assign out_tag          = out_task_r.tag;
  assign out_retries      = out_task_r.retries;
  assign out_backoff_ms   = out_task_r.backoff;
  assign out_last         = out_last_r;

`include "rate_limited_dispatch_queue_assert.svh"

  `RLDQ_ASSERT_NOW(a_occ_bound, clk, rst_n, 1'b1, occ_r <= OCC_W'(QUEUE_DEPTH), "occupancy overflow")
  `RLDQ_ASSERT_NOW(a_disp_not_acc, clk, rst_n, out_valid_r && out_disp_r, !out_acc_r, "dispatch beat marked accepted")
  `RLDQ_ASSERT_NEXT(a_disp_pop, clk, rst_n, state_r == ST_READ && can_disp, occ_r == $past(occ_r) - OCC_W'(1) && state_r == ST_OUT, "dispatch did not pop")
  `RLDQ_ASSERT_NOW(a_enq_room, clk, rst_n, ram_we, QLIM_W'(occ_r) < cfg.qlimit && !ram_re, "store write without room")

endmodule
